### hdl/mbrh_pkg.sv
// ----------------------------------------------------------------------------
// mbrh_pkg
// Shared types, codes and the CRC-16 step for the read-holding-registers
// transaction unit.
// ----------------------------------------------------------------------------
package mbrh_pkg;

    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam int          FRAME_OVERHEAD = 5;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_RX    = 1'b1;

    localparam logic [1:0] ITEM_REQ    = 2'd0;
    localparam logic [1:0] ITEM_DATA   = 2'd1;
    localparam logic [1:0] ITEM_STATUS = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_COUNT = 3'd1;
    localparam logic [2:0] ST_CRC        = 3'd2;
    localparam logic [2:0] ST_EXCEPTION  = 3'd3;
    localparam logic [2:0] ST_LENGTH     = 3'd4;
    localparam logic [2:0] ST_HEADER     = 3'd5;
    localparam logic [2:0] ST_BYTECOUNT  = 3'd6;
    localparam logic [2:0] ST_OVERFLOW   = 3'd7;

    typedef enum logic [1:0] {
        OSEL_REQ  = 2'd0,
        OSEL_DATA = 2'd1,
        OSEL_STAT = 2'd2
    } t_out_sel;

    // controller -> datapath
    typedef struct packed {
        logic     req_start;
        logic     rx_take;
        logic     eval;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_zero;
        logic req_last;
        logic data_last;
        logic eval_data;
    } t_sts;

    // One byte of reflected CRC-16, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/mbrh_if.sv
// ----------------------------------------------------------------------------
// mbrh_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mbrh_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  slave_address;
    logic [15:0] start_register;
    logic [4:0]  register_total;
    logic [7:0]  rx_byte;
    logic        rx_last;

    modport source (
        output valid, kind, slave_address, start_register, register_total,
               rx_byte, rx_last,
        input  ready
    );
    modport sink (
        input  valid, kind, slave_address, start_register, register_total,
               rx_byte, rx_last,
        output ready
    );
endinterface

interface mbrh_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_type;
    logic [7:0] byte_value;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic       last;

    modport source (
        output valid, item_type, byte_value, status, exception_code, last,
        input  ready
    );
    modport sink (
        input  valid, item_type, byte_value, status, exception_code, last,
        output ready
    );
endinterface

### hdl/mbrh_ctrl.sv
// ----------------------------------------------------------------------------
// mbrh_ctrl
// Sequencer: accepts items, steps request and response emission, owns the
// output valid flag.
// ----------------------------------------------------------------------------
module mbrh_ctrl
    import mbrh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    input  logic i_in_rx_last,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REQ  = 5'b00010,
        S_EVAL = 5'b00100,
        S_DATA = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.req_start = accept && (i_in_kind == KIND_START);
        o_cmd.rx_take   = accept && (i_in_kind == KIND_RX);
        o_cmd.eval      = 1'b0;
        o_cmd.out_load  = 1'b0;
        o_cmd.out_sel   = OSEL_REQ;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_kind == KIND_START) begin
                        n_state = i_sts.start_zero ? S_STAT : S_REQ;
                    end else if (i_in_rx_last) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_REQ: begin
                o_cmd.out_sel  = OSEL_REQ;
                o_cmd.out_load = slot_free;
                if (slot_free && i_sts.req_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.eval_data ? S_DATA : S_STAT;
            end
            S_DATA: begin
                o_cmd.out_sel  = OSEL_DATA;
                o_cmd.out_load = slot_free;
                if (slot_free && i_sts.data_last) begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                o_cmd.out_sel  = OSEL_STAT;
                o_cmd.out_load = slot_free;
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/mbrh_dp.sv
// ----------------------------------------------------------------------------
// mbrh_dp
// Datapath: request builder, receive buffer with running CRC, frame checks
// and the result payload register.
// ----------------------------------------------------------------------------
module mbrh_dp
    import mbrh_pkg::*;
#(
    parameter int MAX_REGS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_slave_address,
    input  logic [15:0] i_start_register,
    input  logic [4:0]  i_register_total,
    input  logic [7:0]  i_rx_byte,
    output logic [1:0]  o_item_type,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last
);

    localparam int DATA_DEPTH = 2 * MAX_REGS;
    localparam int FRAME_MAX  = DATA_DEPTH + FRAME_OVERHEAD;
    localparam int LEN_W      = $clog2(FRAME_MAX + 1);
    localparam int IDX_W      = $clog2(DATA_DEPTH);
    localparam int CNT_W      = ($clog2(DATA_DEPTH + 1) > 3) ? $clog2(DATA_DEPTH + 1) : 3;
    localparam logic [4:0] MAX_CNT = 5'(MAX_REGS);

    // request and expectation
    logic [7:0]  r_exp_addr;
    logic [4:0]  r_exp_cnt;
    logic [15:0] r_req_reg;
    logic [15:0] r_tx_crc;

    // receive state
    logic [15:0]      r_crc;
    logic [15:0]      r_tail;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_hdr [3];
    logic             r_ovf;
    logic [7:0]       r_mem [DATA_DEPTH];
    logic [7:0]       r_rd_data;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_status;
    logic [7:0]       r_exc;

    logic [1:0] r_out_type;
    logic [7:0] r_out_byte;
    logic [2:0] r_out_status;
    logic [7:0] r_out_exc;
    logic       r_out_last;

    logic [4:0]       cnt_sat;
    logic [7:0]       req_byte;
    logic [LEN_W-1:0] n2_len;
    logic [CNT_W-1:0] n2_cnt;
    logic [7:0]       n2_byte;
    logic [LEN_W-1:0] wr_pos;
    logic [2:0]       eval_status;
    logic [7:0]       eval_exc;

    assign cnt_sat = (i_register_total > MAX_CNT) ? MAX_CNT : i_register_total;
    assign n2_len  = LEN_W'({r_exp_cnt, 1'b0});
    assign n2_cnt  = CNT_W'({r_exp_cnt, 1'b0});
    assign n2_byte = {2'b00, r_exp_cnt, 1'b0};
    assign wr_pos  = r_len - LEN_W'(3);

    always_comb begin
        case (r_cnt[2:0])
            3'd0:    req_byte = r_exp_addr;
            3'd1:    req_byte = FUNC_READ;
            3'd2:    req_byte = r_req_reg[15:8];
            3'd3:    req_byte = r_req_reg[7:0];
            3'd4:    req_byte = 8'h00;
            3'd5:    req_byte = {3'b000, r_exp_cnt};
            3'd6:    req_byte = r_tx_crc[7:0];
            default: req_byte = r_tx_crc[15:8];
        endcase
    end

    // Frame checks in priority order
    always_comb begin
        eval_exc = 8'h00;
        if (r_len < LEN_W'(4) || r_crc != {r_tail[7:0], r_tail[15:8]}) begin
            eval_status = ST_CRC;
        end else if (r_len == LEN_W'(FRAME_OVERHEAD) && r_hdr[1] == (FUNC_READ | EXC_FLAG)) begin
            eval_status = ST_EXCEPTION;
            eval_exc    = r_hdr[2];
        end else if (r_ovf) begin
            eval_status = ST_OVERFLOW;
        end else if (r_len != n2_len + LEN_W'(FRAME_OVERHEAD)) begin
            eval_status = ST_LENGTH;
        end else if (r_hdr[0] != r_exp_addr || r_hdr[1] != FUNC_READ) begin
            eval_status = ST_HEADER;
        end else if (r_hdr[2] != n2_byte) begin
            eval_status = ST_BYTECOUNT;
        end else begin
            eval_status = ST_OK;
        end
    end

    assign o_sts.start_zero = (i_register_total == 5'd0);
    assign o_sts.req_last   = (r_cnt == CNT_W'(7));
    assign o_sts.data_last  = (r_cnt == n2_cnt - CNT_W'(1));
    assign o_sts.eval_data  = (eval_status == ST_OK) && (r_exp_cnt != 5'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.req_start || i_cmd.eval) begin
            n_cnt = '0;
        end else if (i_cmd.out_load && i_cmd.out_sel != OSEL_STAT) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= 8'h00;
            r_exp_cnt  <= 5'd0;
            r_crc      <= CRC_INIT;
            r_tail     <= 16'h0000;
            r_len      <= '0;
            r_hdr[0]   <= 8'h00;
            r_hdr[1]   <= 8'h00;
            r_hdr[2]   <= 8'h00;
            r_ovf      <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.req_start || i_cmd.eval) begin
                r_crc    <= CRC_INIT;
                r_tail   <= 16'h0000;
                r_len    <= '0;
                r_hdr[0] <= 8'h00;
                r_hdr[1] <= 8'h00;
                r_hdr[2] <= 8'h00;
                r_ovf    <= 1'b0;
            end else if (i_cmd.rx_take) begin
                // the last two bytes seen stay out of the CRC until more arrive
                if (r_len >= LEN_W'(2)) begin
                    r_crc <= crc_byte(r_crc, r_tail[15:8]);
                end
                r_tail <= {r_tail[7:0], i_rx_byte};
                if (r_len >= LEN_W'(FRAME_MAX)) begin
                    r_ovf <= 1'b1;
                end else begin
                    if (r_len < LEN_W'(3)) begin
                        r_hdr[r_len[1:0]] <= i_rx_byte;
                    end
                    r_len <= r_len + LEN_W'(1);
                end
            end
            if (i_cmd.req_start) begin
                r_exp_addr <= i_slave_address;
                r_exp_cnt  <= cnt_sat;
            end
        end
    end

    // Receive buffer; drop bytes past the data area
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_take && r_len >= LEN_W'(3) && r_len < LEN_W'(DATA_DEPTH + 3)) begin
            r_mem[wr_pos[IDX_W-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[n_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_start) begin
            r_req_reg <= i_start_register;
            r_tx_crc  <= CRC_INIT;
            r_status  <= ST_ZERO_COUNT;
            r_exc     <= 8'h00;
        end else if (i_cmd.eval) begin
            r_status <= eval_status;
            r_exc    <= eval_exc;
        end
        if (i_cmd.out_load && i_cmd.out_sel == OSEL_REQ && r_cnt < CNT_W'(6)) begin
            r_tx_crc <= crc_byte(r_tx_crc, req_byte);
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OSEL_REQ: begin
                    r_out_type   <= ITEM_REQ;
                    r_out_byte   <= req_byte;
                    r_out_status <= ST_OK;
                    r_out_exc    <= 8'h00;
                    r_out_last   <= (r_cnt == CNT_W'(7));
                end
                OSEL_DATA: begin
                    r_out_type   <= ITEM_DATA;
                    r_out_byte   <= r_rd_data;
                    r_out_status <= ST_OK;
                    r_out_exc    <= 8'h00;
                    r_out_last   <= 1'b0;
                end
                default: begin
                    r_out_type   <= ITEM_STATUS;
                    r_out_byte   <= 8'h00;
                    r_out_status <= r_status;
                    r_out_exc    <= r_exc;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_item_type      = r_out_type;
    assign o_byte_value     = r_out_byte;
    assign o_status         = r_out_status;
    assign o_exception_code = r_out_exc;
    assign o_last           = r_out_last;

endmodule

### hdl/modbus_read_holding_transaction_unit.sv
// ----------------------------------------------------------------------------
// modbus_read_holding_transaction_unit
// Master side of one Modbus RTU read-holding-registers (function 3) exchange.
// ----------------------------------------------------------------------------
// A start item is accepted and then yields the 8 request bytes, one per cycle
// while the output is not stalled, with the CRC built as the bytes go out; a
// start with zero count yields a single status item. A response byte that is
// not the last yields nothing, so bytes stream in at one per cycle. After the
// byte marked last come the frame checks, then, if they pass, the 2n data
// bytes read one per cycle from the receive buffer while the output is not
// stalled, and last the status item. No new item is taken while results of
// the current one are being produced; the output register lets the next item
// in while the final result still waits on the consumer.
module modbus_read_holding_transaction_unit
    import mbrh_pkg::*;
#(
    parameter int MAX_REGS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbrh_in_if.sink     i_in,
    mbrh_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    mbrh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_kind    (i_in.kind),
        .i_in_rx_last (i_in.rx_last),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    mbrh_dp #(
        .MAX_REGS (MAX_REGS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_slave_address  (i_in.slave_address),
        .i_start_register (i_in.start_register),
        .i_register_total (i_in.register_total),
        .i_rx_byte        (i_in.rx_byte),
        .o_item_type      (o_out.item_type),
        .o_byte_value     (o_out.byte_value),
        .o_status         (o_out.status),
        .o_exception_code (o_out.exception_code),
        .o_last           (o_out.last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives start requests and response frames into the read-holding-registers
// transaction unit and checks every result transfer against a cycle-free
// model of the master: request framing with CRC-16, response buffering and
// the ordered frame checks. Directed frames come first, then random exchanges
// under changing idle and stall patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import mbrh_pkg::*;

    localparam int MAX_REGS  = 16;
    localparam int FRAME_MAX = 2 * MAX_REGS + FRAME_OVERHEAD;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic        kind;
        logic [7:0]  slave_address;
        logic [15:0] start_register;
        logic [4:0]  register_total;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] item_type;
        logic [7:0] byte_value;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic       last;
    } t_result;

    // Master-side model and the queue of results it still owes
    class transaction_tracker;
        logic [7:0]  exp_addr;
        logic [4:0]  exp_regs;
        logic [15:0] crc_acc;
        logic [15:0] tail;
        logic [6:0]  rx_len;
        logic [7:0]  hdr[3];
        logic [7:0]  data_buf[2*MAX_REGS];
        bit          ovf;
        t_result     pending_results[$];
        int          errors;

        function new();
            exp_addr = '0;
            exp_regs = '0;
            errors   = 0;
            clear_rx();
        endfunction

        // Reflected CRC-16, one data bit per step, LSB first
        static function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] d);
            logic [15:0] r;
            r = acc;
            for (int k = 0; k < 8; k++) begin
                if (r[0] ^ d[k]) begin
                    r = {1'b0, r[15:1]} ^ CRC_POLY;
                end else begin
                    r = {1'b0, r[15:1]};
                end
            end
            return r;
        endfunction

        function void clear_rx();
            crc_acc = CRC_INIT;
            tail    = '0;
            rx_len  = '0;
            ovf     = 1'b0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function void add_result(logic [1:0] ty, logic [7:0] v, logic [2:0] st,
                                 logic [7:0] ec, logic fin);
            t_result r;
            r.item_type      = ty;
            r.byte_value     = v;
            r.status         = st;
            r.exception_code = ec;
            r.last           = fin;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void take_input(t_in_item it);
            logic [7:0]  req[8];
            logic [4:0]  cnt;
            logic [15:0] c;
            logic [15:0] rx_crc;
            logic [2:0]  st;
            logic [7:0]  ec;
            int          pos;
            int          n2;
            if (it.kind == KIND_START) begin
                clear_rx();
                exp_addr = it.slave_address;
                cnt      = it.register_total;
                if (cnt == 0) begin
                    exp_regs = '0;
                    add_result(ITEM_STATUS, 8'h00, ST_ZERO_COUNT, 8'h00, 1'b1);
                    return;
                end
                if (cnt > MAX_REGS) cnt = 5'(MAX_REGS);
                exp_regs = cnt;
                req = '{exp_addr, FUNC_READ, it.start_register[15:8],
                        it.start_register[7:0], 8'h00, 8'(cnt), 8'h00, 8'h00};
                c = CRC_INIT;
                for (int k = 0; k < 6; k++) c = crc_step(c, req[k]);
                req[6] = c[7:0];
                req[7] = c[15:8];
                for (int k = 0; k < 8; k++) begin
                    add_result(ITEM_REQ, req[k], ST_OK, 8'h00, k == 7);
                end
                return;
            end

            pos = rx_len;
            // the two newest bytes are held back as the candidate CRC
            if (pos >= 2) crc_acc = crc_step(crc_acc, tail[15:8]);
            tail = {tail[7:0], it.rx_byte};
            if (pos >= FRAME_MAX) begin
                ovf = 1'b1;
            end else begin
                if (pos < 3) begin
                    hdr[pos] = it.rx_byte;
                end else if (pos - 3 < 2 * MAX_REGS) begin
                    data_buf[pos-3] = it.rx_byte;
                end
                rx_len = 7'(pos + 1);
            end
            if (!it.rx_last) return;

            n2     = 2 * exp_regs;
            ec     = 8'h00;
            rx_crc = {tail[7:0], tail[15:8]};
            if (rx_len < 4 || crc_acc != rx_crc) begin
                st = ST_CRC;
            end else if (rx_len == FRAME_OVERHEAD && hdr[1] == (FUNC_READ | EXC_FLAG)) begin
                st = ST_EXCEPTION;
                ec = hdr[2];
            end else if (ovf) begin
                st = ST_OVERFLOW;
            end else if (rx_len != n2 + FRAME_OVERHEAD) begin
                st = ST_LENGTH;
            end else if (hdr[0] != exp_addr || hdr[1] != FUNC_READ) begin
                st = ST_HEADER;
            end else if (hdr[2] != n2) begin
                st = ST_BYTECOUNT;
            end else begin
                for (int i = 0; i < n2; i++) begin
                    add_result(ITEM_DATA, data_buf[i], ST_OK, 8'h00, 1'b0);
                end
                st = ST_OK;
            end
            add_result(ITEM_STATUS, 8'h00, st, ec, 1'b1);
            clear_rx();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: type %0d byte %0h status %0d",
                       got.item_type, got.byte_value, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.item_type !== want.item_type) begin
                $error("item_type: expected %0d, got %0d", want.item_type, got.item_type);
                errors++;
            end
            if (got.byte_value !== want.byte_value) begin
                $error("byte_value: expected %0h, got %0h", want.byte_value, got.byte_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.exception_code !== want.exception_code) begin
                $error("exception_code: expected %0h, got %0h",
                       want.exception_code, got.exception_code);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mbrh_in_if  in_if ();
    mbrh_out_if out_if ();

    modbus_read_holding_transaction_unit #(
        .MAX_REGS (MAX_REGS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    transaction_tracker tracker;

    int         send_gap_pct;
    int         stall_pct;
    bit         pressure_on;
    int         accepted_items;
    logic [7:0] gen_addr;
    int         gen_regs;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when pressure is asked
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_on && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else begin
                out_if.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.item_type      = out_if.item_type;
            got.byte_value     = out_if.byte_value;
            got.status         = out_if.status;
            got.exception_code = out_if.exception_code;
            got.last           = out_if.last;
            tracker.check_result(got);
        end
    end

    function automatic t_in_item random_filler();
        t_in_item it;
        it.kind           = 1'($urandom);
        it.slave_address  = 8'($urandom);
        it.start_register = 16'($urandom);
        it.register_total = 5'($urandom);
        it.rx_byte        = 8'($urandom);
        it.rx_last        = 1'($urandom);
        return it;
    endfunction

    function automatic t_byte_q seal(t_byte_q body);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (body[i]) c = transaction_tracker::crc_step(c, body[i]);
        body.insert(body.size(), c[7:0]);
        body.insert(body.size(), c[15:8]);
        return body;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          = 1'b1;
        in_if.kind           = it.kind;
        in_if.slave_address  = it.slave_address;
        in_if.start_register = it.start_register;
        in_if.register_total = it.register_total;
        in_if.rx_byte        = it.rx_byte;
        in_if.rx_last        = it.rx_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.take_input(it);
        accepted_items++;
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic [7:0] addr, input logic [15:0] first_reg,
                              input logic [4:0] total);
        t_in_item it;
        it                = random_filler();
        it.kind           = KIND_START;
        it.slave_address  = addr;
        it.start_register = first_reg;
        it.register_total = total;
        gen_addr          = addr;
        gen_regs          = (total > MAX_REGS) ? MAX_REGS : int'(total);
        send_item(it);
    endtask

    task automatic send_bytes(input t_byte_q frame, input bit mark_last);
        t_in_item it;
        foreach (frame[i]) begin
            it         = random_filler();
            it.kind    = KIND_RX;
            it.rx_byte = frame[i];
            it.rx_last = mark_last && (i == frame.size() - 1);
            send_item(it);
        end
    endtask

    function automatic t_byte_q good_body();
        t_byte_q body;
        body = '{gen_addr, FUNC_READ, 8'(2 * gen_regs)};
        for (int i = 0; i < 2 * gen_regs; i++) body.insert(body.size(), 8'($urandom));
        return body;
    endfunction

    task automatic random_exchange();
        t_byte_q     frame;
        int          variant;
        int          pick;
        int          cut;
        logic [4:0]  total;
        // now and then skip the request so the previous expectations carry over
        if ($urandom_range(9) != 0) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                total = 5'd0;
            end else if (pick == 1) begin
                total = 5'($urandom_range(16, 31));
            end else if (pick == 2) begin
                total = 5'($urandom_range(4, 15));
            end else begin
                total = 5'($urandom_range(1, 3));
            end
            send_start(8'($urandom), 16'($urandom), total);
        end
        variant = $urandom_range(0, 12);
        frame   = good_body();
        case (variant)
            4: begin
                frame = seal('{gen_addr, FUNC_READ | EXC_FLAG, 8'($urandom)});
                send_bytes(frame, 1'b1);
            end
            5: begin
                frame = seal(frame);
                cut   = $urandom_range(frame.size() - 1);
                frame[cut] = frame[cut] ^ (8'h01 << $urandom_range(7));
                send_bytes(frame, 1'b1);
            end
            6: begin
                if ($urandom_range(1) == 0) begin
                    frame.insert(frame.size(), 8'($urandom));
                end else begin
                    void'(frame.pop_back());
                end
                send_bytes(seal(frame), 1'b1);
            end
            7: begin
                if ($urandom_range(1) == 0) begin
                    frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
                end else begin
                    // never toggle the exception flag here
                    frame[1] = FUNC_READ ^ (8'h01 << $urandom_range(6));
                end
                send_bytes(seal(frame), 1'b1);
            end
            8: begin
                frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
                send_bytes(seal(frame), 1'b1);
            end
            9: begin
                frame.delete();
                repeat ($urandom_range(1, 6)) frame.insert(frame.size(), 8'($urandom));
                send_bytes(frame, 1'b1);
            end
            10: begin
                // partial frame, dropped by the next request
                frame = seal(frame);
                cut   = $urandom_range(1, frame.size() - 1);
                frame = frame[0:cut-1];
                send_bytes(frame, 1'b0);
            end
            11: begin
                frame.delete();
                repeat ($urandom_range(FRAME_MAX - 1, FRAME_MAX + 1)) begin
                    frame.insert(frame.size(), 8'($urandom));
                end
                send_bytes(seal(frame), 1'b1);
            end
            default: begin
                send_bytes(seal(frame), 1'b1);
            end
        endcase
    endtask

    initial begin
        int phase_gap[4];
        int phase_stall[4];
        int target;
        phase_gap   = '{0, 54, 0, 10};
        phase_stall = '{0, 0, 54, 10};
        tracker        = new();
        send_gap_pct   = 0;
        stall_pct      = 0;
        pressure_on    = 1'b0;
        accepted_items = 0;
        gen_addr       = '0;
        gen_regs       = 0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.kind           = KIND_START;
        in_if.slave_address  = '0;
        in_if.start_register = '0;
        in_if.register_total = '0;
        in_if.rx_byte        = '0;
        in_if.rx_last        = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero count, then a response checked against length 5
        send_start(8'h00, 16'h0000, 5'd0);
        send_bytes(seal('{8'h00, FUNC_READ, 8'h00}), 1'b1);
        // count above the limit saturates
        send_start(8'hFF, 16'hFFFF, 5'd31);
        // new request drops the previous one
        send_start(8'hA5, 16'h1234, 5'd1);
        send_bytes(seal('{8'hA5, FUNC_READ, 8'h02, 8'hFF, 8'h00}), 1'b1);
        send_bytes(seal('{8'hA5, FUNC_READ | EXC_FLAG, 8'h02}), 1'b1);
        // frame too short to carry a CRC
        send_bytes('{8'hFF}, 1'b1);

        for (int p = 0; p < 4; p++) begin
            send_gap_pct = phase_gap[p];
            stall_pct    = phase_stall[p];
            if (p == 0) pressure_on = 1'b1;
            target = accepted_items + 30;
            while (accepted_items < target) random_exchange();
        end
        in_if.valid = 1'b0;

        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### modbus_read_holding_transaction_unit.f
hdl/mbrh_pkg.sv
hdl/mbrh_if.sv
hdl/mbrh_ctrl.sv
hdl/mbrh_dp.sv
hdl/modbus_read_holding_transaction_unit.sv
verif/testbench.sv
